FILE: hw/rtl/afs_pkg.sv
// afs_pkg: sizes, codes, sequencer states and divider request and response types of the frame scaler
// used by afs_div and aspect_fit_frame_scaler; depends on nothing else
package afs_pkg;

	localparam int MAX_SRC_W   = 1024;
	localparam int MAX_SRC_H   = 1024;
	localparam int MAX_DST_DIM = 4096;

	localparam int PIX_W  = 32;
	localparam int POS_W  = 12;
	localparam int SRC_SW = 11;   // source size register width
	localparam int DST_SW = 13;   // destination size register width
	localparam int SRC_XW = $clog2(MAX_SRC_W);
	localparam int SRC_YW = $clog2(MAX_SRC_H);
	localparam int SRC_AW = SRC_XW + SRC_YW;
	localparam int SRC_DEPTH = MAX_SRC_W * MAX_SRC_H;

	localparam int MUL_W  = 13;   // multiplier operand width
	localparam int PROD_W = 2 * MUL_W;
	localparam int SUM_W  = 28;   // per-channel box sum
	localparam int N_W    = 21;   // pixels in a box
	localparam int DIV_NW = 29;   // dividend width
	localparam int DIV_DW = 21;   // divisor and remainder width
	localparam int DIV_CW = $clog2(DIV_NW);

	typedef enum logic [1:0] {
		CFG_SRC_W = 2'd0,
		CFG_SRC_H = 2'd1,
		CFG_DST_W = 2'd2,
		CFG_DST_H = 2'd3
	} cfg_idx_t;

	localparam int ST_W = 29;
	typedef enum logic [ST_W-1:0] {
		S_IDLE  = 29'd1 << 0,
		S_CHECK = 29'd1 << 1,
		S_UFX   = 29'd1 << 2,
		S_UFY   = 29'd1 << 3,
		S_UMW   = 29'd1 << 4,
		S_UMH   = 29'd1 << 5,
		S_FIT   = 29'd1 << 6,
		S_UDX   = 29'd1 << 7,
		S_UDY   = 29'd1 << 8,
		S_RD    = 29'd1 << 9,
		S_RDW   = 29'd1 << 10,
		S_DP1   = 29'd1 << 11,
		S_DP2   = 29'd1 << 12,
		S_DOW   = 29'd1 << 13,
		S_DQX   = 29'd1 << 14,
		S_DQY   = 29'd1 << 15,
		S_DMX   = 29'd1 << 16,
		S_DMRX  = 29'd1 << 17,
		S_DMY   = 29'd1 << 18,
		S_DMRY  = 29'd1 << 19,
		S_DTX0  = 29'd1 << 20,
		S_DTX1  = 29'd1 << 21,
		S_DTY0  = 29'd1 << 22,
		S_DTY1  = 29'd1 << 23,
		S_DN    = 29'd1 << 24,
		S_SUM   = 29'd1 << 25,
		S_SUMW  = 29'd1 << 26,
		S_DAVG  = 29'd1 << 27,
		S_OUT   = 29'd1 << 28
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_NW-1:0] quo;
		logic [DIV_DW-1:0] rem;
	} div_rsp_t;

endpackage

FILE: hw/rtl/aspect_fit_frame_scaler.sv
// aspect_fit_frame_scaler: source frame store and read-side fit sequencer
// depends on afs_pkg and the shared divider afs_div
//
// Write requests (cmd 0) store one source pixel; pixels outside the
// 1024 x 1024 store are dropped. Read requests (cmd 1) return one destination pixel:
// zero outside the frame or the fitted area, a copy when sizes match, integer
// replication centred when the source fits, otherwise a centred box average with
// per-channel rounded means. The block takes one request at a time and is not ready
// while a read is in progress or its result waits. How long a read takes is set by the
// single divider, which works out one quotient at a time (four per replicated read,
// thirteen per averaged read), and by the single read port of the frame store, which
// sweeps the box one pixel a cycle. Configuration writes are taken at any time and
// must only be issued while the block is idle.
module aspect_fit_frame_scaler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [afs_pkg::DST_SW-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        cmd,
	input  logic [afs_pkg::POS_W-1:0]   pos_x,
	input  logic [afs_pkg::POS_W-1:0]   pos_y,
	input  logic [afs_pkg::PIX_W-1:0]   pixel_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [afs_pkg::PIX_W-1:0]   pixel_out
);

	// configuration registers
	logic [afs_pkg::SRC_SW-1:0] src_width_q, src_height_q;
	logic [afs_pkg::DST_SW-1:0] dst_width_q, dst_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= '0;
			src_height_q <= '0;
			dst_width_q  <= afs_pkg::DST_SW'(640);
			dst_height_q <= afs_pkg::DST_SW'(480);
		end else if (cfg_valid && cfg_ready) begin
			unique case (afs_pkg::cfg_idx_t'(cfg_index))
				afs_pkg::CFG_SRC_W: src_width_q  <= cfg_data[afs_pkg::SRC_SW-1:0];
				afs_pkg::CFG_SRC_H: src_height_q <= cfg_data[afs_pkg::SRC_SW-1:0];
				afs_pkg::CFG_DST_W: dst_width_q  <= cfg_data;
				afs_pkg::CFG_DST_H: dst_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// sizes saturated to what the store and the frame can hold
	logic [afs_pkg::SRC_SW-1:0] lw, lh;
	logic [afs_pkg::DST_SW-1:0] dw, dh;

	assign lw = (src_width_q > afs_pkg::SRC_SW'(afs_pkg::MAX_SRC_W)) ?
		afs_pkg::SRC_SW'(afs_pkg::MAX_SRC_W) : src_width_q;
	assign lh = (src_height_q > afs_pkg::SRC_SW'(afs_pkg::MAX_SRC_H)) ?
		afs_pkg::SRC_SW'(afs_pkg::MAX_SRC_H) : src_height_q;
	assign dw = (dst_width_q > afs_pkg::DST_SW'(afs_pkg::MAX_DST_DIM)) ?
		afs_pkg::DST_SW'(afs_pkg::MAX_DST_DIM) : dst_width_q;
	assign dh = (dst_height_q > afs_pkg::DST_SW'(afs_pkg::MAX_DST_DIM)) ?
		afs_pkg::DST_SW'(afs_pkg::MAX_DST_DIM) : dst_height_q;

	afs_pkg::state_t state_q, state_d;
	logic issued_q;          // divide in flight for the current state
	logic acc_v_s1;          // frame read data valid for the box sum

	// working registers
	logic [afs_pkg::POS_W-1:0]   x_q, y_q;
	logic [afs_pkg::DST_SW-1:0]  scale_q;
	logic [afs_pkg::DST_SW-1:0]  out_w_q, out_h_q;
	logic [afs_pkg::DST_SW-1:0]  rel_x_q, rel_y_q;
	logic [afs_pkg::SRC_XW-1:0]  sx_q;
	logic [afs_pkg::SRC_YW-1:0]  sy_q;
	logic [22:0]                 p1_q, p2_q;
	logic [afs_pkg::SRC_SW-1:0]  qx_q, qy_q;
	logic [afs_pkg::DST_SW-1:0]  rx_q, ry_q;
	logic [afs_pkg::SRC_SW-1:0]  px_q, py_q;
	logic [24:0]                 prx_q, pry_q;
	logic [afs_pkg::SRC_SW-1:0]  x0_q, x1_q, y0_q, y1_q;
	logic [afs_pkg::SRC_SW-1:0]  cx_q, cy_q;
	logic [afs_pkg::N_W-1:0]     n_q;
	logic [afs_pkg::SUM_W-1:0]   sum_q [4];
	logic [1:0]                  ch_q;
	logic                        down_q;
	logic [afs_pkg::PIX_W-1:0]   res_q;
	logic [afs_pkg::PIX_W-1:0]   rdata_q;

	// frame store: one write port, one registered read port
	logic [afs_pkg::PIX_W-1:0]  frame_mem [afs_pkg::SRC_DEPTH];
	logic                       wr_en;
	logic [afs_pkg::SRC_AW-1:0] wr_addr, rd_addr;

	assign wr_en = in_valid && in_ready && !cmd
		&& pos_x < afs_pkg::POS_W'(afs_pkg::MAX_SRC_W)
		&& pos_y < afs_pkg::POS_W'(afs_pkg::MAX_SRC_H);
	assign wr_addr = {pos_y[afs_pkg::SRC_YW-1:0], pos_x[afs_pkg::SRC_XW-1:0]};
	assign rd_addr = (state_q == afs_pkg::S_SUM) ?
		{cy_q[afs_pkg::SRC_YW-1:0], cx_q[afs_pkg::SRC_XW-1:0]} : {sy_q, sx_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= pixel_in;
		end
		rdata_q <= frame_mem[rd_addr];
	end

	// shared multiplier
	logic [afs_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic [afs_pkg::PROD_W-1:0] mul_p;
	logic [afs_pkg::SRC_SW-1:0] bw, bh;

	assign bw = x1_q - x0_q;
	assign bh = y1_q - y0_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			afs_pkg::S_UMW:  begin mul_a = afs_pkg::MUL_W'(lw);      mul_b = scale_q; end
			afs_pkg::S_UMH:  begin mul_a = afs_pkg::MUL_W'(lh);      mul_b = scale_q; end
			afs_pkg::S_DP1:  begin mul_a = dw;                       mul_b = afs_pkg::MUL_W'(lh); end
			afs_pkg::S_DP2:  begin mul_a = dh;                       mul_b = afs_pkg::MUL_W'(lw); end
			afs_pkg::S_DMX:  begin mul_a = rel_x_q; mul_b = afs_pkg::MUL_W'(qx_q); end
			afs_pkg::S_DMRX: begin mul_a = rel_x_q; mul_b = rx_q; end
			afs_pkg::S_DMY:  begin mul_a = rel_y_q; mul_b = afs_pkg::MUL_W'(qy_q); end
			afs_pkg::S_DMRY: begin mul_a = rel_y_q; mul_b = ry_q; end
			afs_pkg::S_DN:   begin mul_a = afs_pkg::MUL_W'(bw); mul_b = afs_pkg::MUL_W'(bh); end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// shared divider
	afs_pkg::div_req_t div_req;
	afs_pkg::div_rsp_t div_rsp;
	logic              div_state;
	logic              div_done;
	logic              p_le;

	assign p_le = p1_q <= p2_q;

	always_comb begin
		div_req.num = '0;
		div_req.den = afs_pkg::DIV_DW'(1);
		div_state   = 1'b1;
		case (state_q)
			afs_pkg::S_UFX: begin
				div_req.num = afs_pkg::DIV_NW'(dw); div_req.den = afs_pkg::DIV_DW'(lw);
			end
			afs_pkg::S_UFY: begin
				div_req.num = afs_pkg::DIV_NW'(dh); div_req.den = afs_pkg::DIV_DW'(lh);
			end
			afs_pkg::S_UDX: begin
				div_req.num = afs_pkg::DIV_NW'(rel_x_q); div_req.den = afs_pkg::DIV_DW'(scale_q);
			end
			afs_pkg::S_UDY: begin
				div_req.num = afs_pkg::DIV_NW'(rel_y_q); div_req.den = afs_pkg::DIV_DW'(scale_q);
			end
			afs_pkg::S_DOW: begin
				div_req.num = p_le ? afs_pkg::DIV_NW'(p1_q) : afs_pkg::DIV_NW'(p2_q);
				div_req.den = p_le ? afs_pkg::DIV_DW'(lw) : afs_pkg::DIV_DW'(lh);
			end
			afs_pkg::S_DQX: begin
				div_req.num = afs_pkg::DIV_NW'(lw); div_req.den = afs_pkg::DIV_DW'(out_w_q);
			end
			afs_pkg::S_DQY: begin
				div_req.num = afs_pkg::DIV_NW'(lh); div_req.den = afs_pkg::DIV_DW'(out_h_q);
			end
			afs_pkg::S_DTX0: begin
				div_req.num = afs_pkg::DIV_NW'(prx_q); div_req.den = afs_pkg::DIV_DW'(out_w_q);
			end
			afs_pkg::S_DTX1: begin
				div_req.num = afs_pkg::DIV_NW'(prx_q) + afs_pkg::DIV_NW'(rx_q);
				div_req.den = afs_pkg::DIV_DW'(out_w_q);
			end
			afs_pkg::S_DTY0: begin
				div_req.num = afs_pkg::DIV_NW'(pry_q); div_req.den = afs_pkg::DIV_DW'(out_h_q);
			end
			afs_pkg::S_DTY1: begin
				div_req.num = afs_pkg::DIV_NW'(pry_q) + afs_pkg::DIV_NW'(ry_q);
				div_req.den = afs_pkg::DIV_DW'(out_h_q);
			end
			afs_pkg::S_DAVG: begin
				// rounded mean: (sum + n/2) / n
				div_req.num = afs_pkg::DIV_NW'(sum_q[ch_q]) + afs_pkg::DIV_NW'(n_q >> 1);
				div_req.den = afs_pkg::DIV_DW'(n_q);
			end
			default: div_state = 1'b0;
		endcase
	end

	assign div_req.start = div_state && !issued_q && !div_rsp.busy;
	assign div_done      = div_state && issued_q && div_rsp.done;

	afs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// helpers for the decisions of the sequencer
	logic [afs_pkg::DST_SW-1:0] xw, yw, off_x, off_y, fy, scale_min;
	logic                       outside_frame, outside_fit, same_size, box_empty;
	logic                       last_col, last_row;

	assign xw    = afs_pkg::DST_SW'(x_q);
	assign yw    = afs_pkg::DST_SW'(y_q);
	assign off_x = (dw - out_w_q) >> 1;
	assign off_y = (dh - out_h_q) >> 1;
	assign fy    = div_rsp.quo[afs_pkg::DST_SW-1:0];
	assign scale_min = (fy < scale_q) ? fy : scale_q;

	assign outside_frame = xw >= dw || yw >= dh || lw == '0 || lh == '0;
	assign same_size     = afs_pkg::DST_SW'(lw) == dw && afs_pkg::DST_SW'(lh) == dh;
	assign outside_fit   = xw < off_x || (xw - off_x) >= out_w_q
		|| yw < off_y || (yw - off_y) >= out_h_q;
	assign box_empty     = bw == '0 || bh == '0;
	assign last_col      = cx_q + 1'b1 == x1_q;
	assign last_row      = cy_q + 1'b1 == y1_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			afs_pkg::S_IDLE:  if (in_valid && cmd) state_d = afs_pkg::S_CHECK;
			afs_pkg::S_CHECK: begin
				if (outside_frame)  state_d = afs_pkg::S_OUT;
				else if (same_size) state_d = afs_pkg::S_RD;
				else                state_d = afs_pkg::S_UFX;
			end
			afs_pkg::S_UFX:  if (div_done) state_d = afs_pkg::S_UFY;
			afs_pkg::S_UFY:  if (div_done)
				state_d = (scale_min == '0) ? afs_pkg::S_DP1 : afs_pkg::S_UMW;
			afs_pkg::S_UMW:  state_d = afs_pkg::S_UMH;
			afs_pkg::S_UMH:  state_d = afs_pkg::S_FIT;
			afs_pkg::S_FIT: begin
				if (outside_fit) state_d = afs_pkg::S_OUT;
				else             state_d = down_q ? afs_pkg::S_DQX : afs_pkg::S_UDX;
			end
			afs_pkg::S_UDX:  if (div_done) state_d = afs_pkg::S_UDY;
			afs_pkg::S_UDY:  if (div_done) state_d = afs_pkg::S_RD;
			afs_pkg::S_RD:   state_d = afs_pkg::S_RDW;
			afs_pkg::S_RDW:  state_d = afs_pkg::S_OUT;
			afs_pkg::S_DP1:  state_d = afs_pkg::S_DP2;
			afs_pkg::S_DP2:  state_d = afs_pkg::S_DOW;
			afs_pkg::S_DOW:  if (div_done) state_d = afs_pkg::S_FIT;
			afs_pkg::S_DQX:  if (div_done) state_d = afs_pkg::S_DQY;
			afs_pkg::S_DQY:  if (div_done) state_d = afs_pkg::S_DMX;
			afs_pkg::S_DMX:  state_d = afs_pkg::S_DMRX;
			afs_pkg::S_DMRX: state_d = afs_pkg::S_DMY;
			afs_pkg::S_DMY:  state_d = afs_pkg::S_DMRY;
			afs_pkg::S_DMRY: state_d = afs_pkg::S_DTX0;
			afs_pkg::S_DTX0: if (div_done) state_d = afs_pkg::S_DTX1;
			afs_pkg::S_DTX1: if (div_done) state_d = afs_pkg::S_DTY0;
			afs_pkg::S_DTY0: if (div_done) state_d = afs_pkg::S_DTY1;
			afs_pkg::S_DTY1: if (div_done) state_d = afs_pkg::S_DN;
			afs_pkg::S_DN:   state_d = box_empty ? afs_pkg::S_OUT : afs_pkg::S_SUM;
			afs_pkg::S_SUM:  if (last_col && last_row) state_d = afs_pkg::S_SUMW;
			afs_pkg::S_SUMW: state_d = afs_pkg::S_DAVG;
			afs_pkg::S_DAVG: if (div_done && ch_q == 2'd3) state_d = afs_pkg::S_OUT;
			afs_pkg::S_OUT:  if (out_ready) state_d = afs_pkg::S_IDLE;
			default:         state_d = afs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= afs_pkg::S_IDLE;
			issued_q <= 1'b0;
			acc_v_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			acc_v_s1 <= state_q == afs_pkg::S_SUM;
			if (div_req.start)     issued_q <= 1'b1;
			else if (div_rsp.done) issued_q <= 1'b0;
		end
	end

	// datapath captures
	always_ff @(posedge clk) begin
		if (acc_v_s1) begin
			for (int k = 0; k < 4; k++) begin
				sum_q[k] <= sum_q[k] + afs_pkg::SUM_W'(rdata_q[8*k +: 8]);
			end
		end
		case (state_q)
			afs_pkg::S_IDLE: begin
				x_q <= pos_x;
				y_q <= pos_y;
			end
			afs_pkg::S_CHECK: begin
				res_q <= '0;
				sx_q  <= x_q[afs_pkg::SRC_XW-1:0];
				sy_q  <= y_q[afs_pkg::SRC_YW-1:0];
			end
			afs_pkg::S_UFX: if (div_done) scale_q <= div_rsp.quo[afs_pkg::DST_SW-1:0];
			afs_pkg::S_UFY: if (div_done) begin
				scale_q <= scale_min;
				down_q  <= scale_min == '0;
			end
			afs_pkg::S_UMW: out_w_q <= mul_p[afs_pkg::DST_SW-1:0];
			afs_pkg::S_UMH: out_h_q <= mul_p[afs_pkg::DST_SW-1:0];
			afs_pkg::S_FIT: begin
				rel_x_q <= xw - off_x;
				rel_y_q <= yw - off_y;
			end
			afs_pkg::S_UDX: if (div_done) sx_q <= div_rsp.quo[afs_pkg::SRC_XW-1:0];
			afs_pkg::S_UDY: if (div_done) sy_q <= div_rsp.quo[afs_pkg::SRC_YW-1:0];
			afs_pkg::S_RDW: res_q <= rdata_q;
			afs_pkg::S_DP1: p1_q <= mul_p[22:0];
			afs_pkg::S_DP2: p2_q <= mul_p[22:0];
			afs_pkg::S_DOW: if (div_done) begin
				// fitted size along the axis that does not fill the frame, never below one pixel
				if (p_le) begin
					out_w_q <= dw;
					out_h_q <= (div_rsp.quo == '0) ? afs_pkg::DST_SW'(1) :
						div_rsp.quo[afs_pkg::DST_SW-1:0];
				end else begin
					out_h_q <= dh;
					out_w_q <= (div_rsp.quo == '0) ? afs_pkg::DST_SW'(1) :
						div_rsp.quo[afs_pkg::DST_SW-1:0];
				end
			end
			afs_pkg::S_DQX: if (div_done) begin
				qx_q <= div_rsp.quo[afs_pkg::SRC_SW-1:0];
				rx_q <= div_rsp.rem[afs_pkg::DST_SW-1:0];
			end
			afs_pkg::S_DQY: if (div_done) begin
				qy_q <= div_rsp.quo[afs_pkg::SRC_SW-1:0];
				ry_q <= div_rsp.rem[afs_pkg::DST_SW-1:0];
			end
			afs_pkg::S_DMX:  px_q  <= mul_p[afs_pkg::SRC_SW-1:0];
			afs_pkg::S_DMRX: prx_q <= mul_p[24:0];
			afs_pkg::S_DMY:  py_q  <= mul_p[afs_pkg::SRC_SW-1:0];
			afs_pkg::S_DMRY: pry_q <= mul_p[24:0];
			// box edges: i*q plus the spread share of the remainder
			afs_pkg::S_DTX0: if (div_done)
				x0_q <= px_q + div_rsp.quo[afs_pkg::SRC_SW-1:0];
			afs_pkg::S_DTX1: if (div_done)
				x1_q <= px_q + qx_q + div_rsp.quo[afs_pkg::SRC_SW-1:0];
			afs_pkg::S_DTY0: if (div_done)
				y0_q <= py_q + div_rsp.quo[afs_pkg::SRC_SW-1:0];
			afs_pkg::S_DTY1: if (div_done)
				y1_q <= py_q + qy_q + div_rsp.quo[afs_pkg::SRC_SW-1:0];
			afs_pkg::S_DN: begin
				n_q  <= mul_p[afs_pkg::N_W-1:0];
				cx_q <= x0_q;
				cy_q <= y0_q;
				ch_q <= '0;
				for (int k = 0; k < 4; k++) begin
					sum_q[k] <= '0;
				end
			end
			afs_pkg::S_SUM: begin
				if (last_col) begin
					cx_q <= x0_q;
					cy_q <= cy_q + 1'b1;
				end else begin
					cx_q <= cx_q + 1'b1;
				end
			end
			afs_pkg::S_DAVG: if (div_done) begin
				// channels come out low byte first and shift down into place
				res_q <= {div_rsp.quo[7:0], res_q[afs_pkg::PIX_W-1:8]};
				ch_q  <= ch_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign in_ready  = state_q == afs_pkg::S_IDLE;
	assign out_valid = state_q == afs_pkg::S_OUT;
	assign pixel_out = res_q;

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy && !issued_q)
		else $error("divider started while a divide is in flight");

	a_box_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == afs_pkg::S_SUM |-> cx_q < x1_q && cy_q < y1_q && cx_q >= x0_q)
		else $error("box sweep left its box");

	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> state_q == afs_pkg::S_IDLE)
		else $error("sequencer did not return to idle after the result");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != afs_pkg::S_IDLE |-> !in_ready)
		else $error("request taken while a read is in progress");

endmodule

FILE: hw/rtl/afs_div.sv
// afs_div: shared restoring divider, one quotient bit per cycle
// depends on afs_pkg for widths and the request and response structs
module afs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  afs_pkg::div_req_t  req,
	output afs_pkg::div_rsp_t  rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [afs_pkg::DIV_CW-1:0]  cnt_q;
	logic [afs_pkg::DIV_DW-1:0]  acc_q;
	logic [afs_pkg::DIV_NW-1:0]  quo_q;
	logic [afs_pkg::DIV_DW-1:0]  den_q;
	logic [afs_pkg::DIV_DW:0]    trial;
	logic [afs_pkg::DIV_DW:0]    diff;
	logic                        ge;

	assign trial = {acc_q, quo_q[afs_pkg::DIV_NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			acc_q <= '0;
			cnt_q <= afs_pkg::DIV_CW'(afs_pkg::DIV_NW - 1);
		end else if (busy_q) begin
			// partial remainder always stays below the divisor
			acc_q <= ge ? diff[afs_pkg::DIV_DW-1:0] : trial[afs_pkg::DIV_DW-1:0];
			quo_q <= {quo_q[afs_pkg::DIV_NW-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = acc_q;

endmodule
